>>> sv/psd_pkg.sv
// Package for the pair sum detector: field widths, register map, microcode
// step and condition codes, control word and the microcode ROM.
// No dependencies.
package psd_pkg;

  localparam int VALUE_W       = 32;
  localparam int SUM_W         = 33;
  localparam int MAX_ITEMS_DEF = 64;

  // APB register map: one 33-bit register, so 64-bit data and 8-byte slots
  localparam int APB_DW = 64;
  localparam int APB_AW = 3;
  localparam logic [APB_AW-1:0] REG_TARGET_SUM = 3'd0;

  // microcode addresses
  typedef enum logic [2:0] {
    S_LOAD,
    S_OUTER,
    S_LATCH,
    S_SCAN,
    S_NEXT,
    S_EMIT
  } step_t;

  // jump conditions
  typedef enum logic [2:0] {
    C_ALWAYS,
    C_IN_LAST,
    C_NO_PAIR,
    C_INNER_END,
    C_OUT_FREE
  } cond_t;

  typedef struct packed {
    logic  in_rdy;     // take an input word
    logic  rd_outer;   // read port addressed by outer index
    logic  rd_inner;   // read port addressed by inner index, inner advances unless it equals count
    logic  set_inner;  // inner <= outer + 1
    logic  lat_a;      // latch read data as first operand
    logic  cmp;        // compare first operand + read data with target
    logic  inc_outer;  // outer advances
    logic  emit;       // load result register and clear list (when cond true)
    cond_t cond;
    step_t tgt_true;
    step_t tgt_false;
  } ctrl_t;

  function automatic ctrl_t ucode(step_t s);
    ctrl_t w;
    w = '0;
    w.cond      = C_ALWAYS;
    w.tgt_true  = S_LOAD;
    w.tgt_false = S_LOAD;
    unique case (s)
      S_LOAD: begin
        w.in_rdy    = 1'b1;
        w.cond      = C_IN_LAST;
        w.tgt_true  = S_OUTER;
        w.tgt_false = S_LOAD;
      end
      S_OUTER: begin
        w.rd_outer  = 1'b1;
        w.set_inner = 1'b1;
        w.cond      = C_NO_PAIR;
        w.tgt_true  = S_EMIT;
        w.tgt_false = S_LATCH;
      end
      S_LATCH: begin
        w.lat_a     = 1'b1;
        w.rd_inner  = 1'b1;
        w.cond      = C_INNER_END;
        w.tgt_true  = S_NEXT;
        w.tgt_false = S_SCAN;
      end
      S_SCAN: begin
        w.cmp       = 1'b1;
        w.rd_inner  = 1'b1;
        w.cond      = C_INNER_END;
        w.tgt_true  = S_NEXT;
        w.tgt_false = S_SCAN;
      end
      S_NEXT: begin
        w.inc_outer = 1'b1;
        w.cond      = C_ALWAYS;
        w.tgt_true  = S_OUTER;
        w.tgt_false = S_OUTER;
      end
      S_EMIT: begin
        w.emit      = 1'b1;
        w.cond      = C_OUT_FREE;
        w.tgt_true  = S_LOAD;
        w.tgt_false = S_EMIT;
      end
      default: begin
        w.cond      = C_ALWAYS;
        w.tgt_true  = S_LOAD;
        w.tgt_false = S_LOAD;
      end
    endcase
    return w;
  endfunction

endpackage

>>> sv/psd_in_if.sv
// Input channel of the pair sum detector: valid/ready plus one list word.
// Depends on psd_pkg.
interface psd_in_if import psd_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [VALUE_W-1:0] value;
  logic               last;

  modport source (output valid, output value, output last, input ready);
  modport sink   (input valid, input value, input last, output ready);
endinterface

>>> sv/psd_out_if.sv
// Result channel of the pair sum detector: valid/ready plus result flags.
// Depends on psd_pkg.
interface psd_out_if import psd_pkg::*; ();
  logic valid;
  logic ready;
  logic found;
  logic overflowed;

  modport source (output valid, output found, output overflowed, input ready);
  modport sink   (input valid, input found, input overflowed, output ready);
endinterface

>>> sv/psd_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module psd_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> sv/pair_sum_detector_top.sv
// Pair sum detector top level: microcoded sequencer over a list store.
// Depends on psd_pkg, psd_in_if, psd_out_if and psd_ram.
//
//  channel  | dir | handshake      | word
//  ---------+-----+----------------+---------------------------------
//  item     | in  | valid/ready    | value[31:0] signed, last
//  result   | out | valid/ready    | found, overflowed
//  apb      | in  | psel/penable   | target_sum at byte address 0
//
// Loading takes one word per cycle. After the last word the search walks
// the store through the single RAM read port, one pair per cycle, then
// loads the result register. rst clears the sequencer, counters and the
// result valid flag; store contents and result flags are not cleared. A
// pending result waits in its register while the next list loads; the
// sequencer holds in its emit step only if that register is still full.
module pair_sum_detector_top import psd_pkg::*; #(
  parameter int MAX_ITEMS = MAX_ITEMS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  psd_in_if.sink            item,
  psd_out_if.source         result,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready
);

  localparam int IDX_W = $clog2(MAX_ITEMS);
  localparam int CNT_W = $clog2(MAX_ITEMS + 1);

  step_t              step;
  ctrl_t              ctrl;
  logic               cond_ok;

  logic [CNT_W-1:0]   count;
  logic [CNT_W-1:0]   outer;
  logic [CNT_W-1:0]   inner;
  logic [CNT_W-1:0]   outer_inc;
  logic               dropped;
  logic               pair_found;
  logic [VALUE_W-1:0] opa;
  logic [SUM_W-1:0]   target_sum;
  logic [SUM_W-1:0]   pair_sum;
  logic               hit;

  logic               res_valid;
  logic               res_found;
  logic               res_over;

  logic               accept;
  logic               store_we;
  logic [IDX_W-1:0]   raddr;
  logic [VALUE_W-1:0] rdata;

  // configuration
  assign pready = 1'b1;
  assign prdata = (paddr == REG_TARGET_SUM)
                ? {{(APB_DW-SUM_W){target_sum[SUM_W-1]}}, target_sum}
                : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      target_sum <= '0;
    end else if (psel && penable && pwrite && paddr == REG_TARGET_SUM) begin
      target_sum <= pwdata[SUM_W-1:0];
    end
  end

  // sequencer
  assign ctrl      = ucode(step);
  assign outer_inc = outer + CNT_W'(1);
  assign accept    = ctrl.in_rdy && item.valid;
  assign store_we  = accept && (count < CNT_W'(MAX_ITEMS));

  always_comb begin
    unique case (ctrl.cond)
      C_ALWAYS:    cond_ok = 1'b1;
      C_IN_LAST:   cond_ok = item.valid && item.last;
      C_NO_PAIR:   cond_ok = outer_inc >= count;
      C_INNER_END: cond_ok = inner == count;
      C_OUT_FREE:  cond_ok = !res_valid || result.ready;
      default:     cond_ok = 1'b1;
    endcase
  end

  assign item.ready = ctrl.in_rdy;

  // datapath
  assign raddr    = ctrl.rd_outer ? outer[IDX_W-1:0] : inner[IDX_W-1:0];
  assign pair_sum = {opa[VALUE_W-1], opa} + {rdata[VALUE_W-1], rdata};
  assign hit      = pair_sum == target_sum;

  psd_ram #(
    .WIDTH (VALUE_W),
    .DEPTH (MAX_ITEMS)
  ) u_store (
    .clk   (clk),
    .we    (store_we),
    .waddr (count[IDX_W-1:0]),
    .wdata (item.value),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      step       <= S_LOAD;
      count      <= '0;
      outer      <= '0;
      inner      <= '0;
      dropped    <= 1'b0;
      pair_found <= 1'b0;
      res_valid  <= 1'b0;
    end else begin
      step <= cond_ok ? ctrl.tgt_true : ctrl.tgt_false;

      if (accept) begin
        if (store_we) begin
          count <= count + CNT_W'(1);
        end else begin
          dropped <= 1'b1;
        end
      end

      if (ctrl.set_inner) begin
        inner <= outer_inc;
      end else if (ctrl.rd_inner && !cond_ok) begin
        inner <= inner + CNT_W'(1);
      end
      if (ctrl.inc_outer) begin
        outer <= outer_inc;
      end
      if (ctrl.cmp && hit) begin
        pair_found <= 1'b1;
      end

      if (ctrl.emit && cond_ok) begin
        res_valid  <= 1'b1;
        count      <= '0;
        outer      <= '0;
        inner      <= '0;
        dropped    <= 1'b0;
        pair_found <= 1'b0;
      end else if (result.ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (ctrl.lat_a) begin
      opa <= rdata;
    end
    if (ctrl.emit && cond_ok) begin
      res_found <= pair_found;
      res_over  <= dropped;
    end
  end

  assign result.valid      = res_valid;
  assign result.found      = res_found;
  assign result.overflowed = res_over;

  // checks
  a_count_cap: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(MAX_ITEMS))
    else $error("stored count beyond store capacity");

  a_scan_range: assert property (@(posedge clk) disable iff (rst)
    step == S_SCAN |-> (inner <= count) && (outer < count))
    else $error("scan indices outside the stored list");

  a_last_starts_search: assert property (@(posedge clk) disable iff (rst)
    item.valid && item.ready && item.last |=> step == S_OUTER)
    else $error("closing word did not start the search");

  a_result_from_emit: assert property (@(posedge clk) disable iff (rst)
    $rose(result.valid) |-> $past(step == S_EMIT))
    else $error("result raised outside the emit step");

endmodule
